/* sv/vtpd_pkg.sv */
// Shared constants and types for the vertex transform block.
`default_nettype none
package vtpd_pkg;

    localparam int DATA_W        = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int NUM_REGS      = 8;
    localparam int REG_W         = 64;
    localparam int ADDR_W        = 6;
    localparam int DIV_STEPS     = 32;
    // divider: one prep stage, one stage per quotient bit, one output stage
    localparam int DIV_LAT       = DIV_STEPS + 2;

    localparam logic [REG_W-1:0] REG_RESET [NUM_REGS] = '{
        64'd65536, 64'd0, 64'd281474976710656, 64'd0,
        64'd0, 64'd65536, 64'd0, 64'd281474976710656
    };

    localparam logic [DATA_W-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] SAT_NEG = 32'h8000_0000;

    // w-related flags carried alongside the dividers
    typedef struct packed {
        logic              wz;
        logic              wovf;
        logic [DATA_W-1:0] wsat;
    } side_t;

endpackage
`default_nettype wire

/* sv/vtpd_divider.sv */
// Pipelined restoring divider: (num * 2^FRAC_BITS) / den, truncated, saturated.
`default_nettype none
module vtpd_divider #(
    parameter int FRAC_BITS = vtpd_pkg::FRAC_BITS_DEF,
    parameter int ACC_W     = 66 - vtpd_pkg::FRAC_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        en,
    input  wire logic [ACC_W-1:0]            num,
    input  wire logic [ACC_W-1:0]            den,
    output logic      [vtpd_pkg::DATA_W-1:0] quot,
    output logic                             ovf
);
    import vtpd_pkg::*;

    localparam int NW = ACC_W + FRAC_BITS;
    localparam int HW = NW - DATA_W;

    logic [ACC_W-1:0]  n_mag;
    logic [ACC_W-1:0]  d_mag;
    logic [NW-1:0]     n_full;
    logic [HW-1:0]     n_hi;
    logic              pre_ovf;

    logic [ACC_W-1:0]  rem_reg [0:DIV_STEPS];
    logic [DATA_W-1:0] nlo_reg [0:DIV_STEPS];
    logic [DATA_W-1:0] q_reg   [0:DIV_STEPS];
    logic [ACC_W-1:0]  d_reg   [0:DIV_STEPS];
    logic              neg_reg [0:DIV_STEPS];
    logic              pre_reg [0:DIV_STEPS];

    logic [ACC_W-1:0]  rem_next [1:DIV_STEPS];
    logic [DATA_W-1:0] q_next   [1:DIV_STEPS];
    logic [ACC_W:0]    trial    [1:DIV_STEPS];

    logic [DATA_W-1:0] quot_reg;
    logic [DATA_W-1:0] quot_next;
    logic              ovf_reg;
    logic              ovf_next;
    logic [DATA_W-1:0] qf;

    // magnitudes and quotient-range precheck
    always_comb
    begin
        n_mag   = num[ACC_W-1] ? (~num + 1'b1) : num;
        d_mag   = den[ACC_W-1] ? (~den + 1'b1) : den;
        n_full  = NW'(n_mag) << FRAC_BITS;
        n_hi    = n_full[NW-1:DATA_W];
        pre_ovf = ACC_W'(n_hi) >= d_mag;
    end

    // one quotient bit per stage
    always_comb
    begin
        for (int k = 1; k <= DIV_STEPS; k++)
        begin
            trial[k] = {rem_reg[k-1], nlo_reg[k-1][DATA_W-1]};
            if (trial[k] >= {1'b0, d_reg[k-1]})
            begin
                rem_next[k] = ACC_W'(trial[k] - {1'b0, d_reg[k-1]});
                q_next[k]   = {q_reg[k-1][DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[k] = trial[k][ACC_W-1:0];
                q_next[k]   = {q_reg[k-1][DATA_W-2:0], 1'b0};
            end
        end
    end

    // sign and saturation
    always_comb
    begin
        qf        = q_reg[DIV_STEPS];
        quot_next = qf;
        ovf_next  = 1'b0;
        if (neg_reg[DIV_STEPS])
        begin
            if (pre_reg[DIV_STEPS] || qf > SAT_NEG)
            begin
                quot_next = SAT_NEG;
                ovf_next  = 1'b1;
            end
            else
            begin
                quot_next = ~qf + 1'b1;
            end
        end
        else if (pre_reg[DIV_STEPS] || qf > SAT_POS)
        begin
            quot_next = SAT_POS;
            ovf_next  = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= ACC_W'(n_hi);
            nlo_reg[0] <= n_full[DATA_W-1:0];
            q_reg[0]   <= '0;
            d_reg[0]   <= d_mag;
            neg_reg[0] <= num[ACC_W-1] ^ den[ACC_W-1];
            pre_reg[0] <= pre_ovf;
            for (int k = 1; k <= DIV_STEPS; k++)
            begin
                rem_reg[k] <= rem_next[k];
                nlo_reg[k] <= {nlo_reg[k-1][DATA_W-2:0], 1'b0};
                q_reg[k]   <= q_next[k];
                d_reg[k]   <= d_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
                pre_reg[k] <= pre_reg[k-1];
            end
            quot_reg <= quot_next;
            ovf_reg  <= ovf_next;
        end
    end

    assign quot = quot_reg;
    assign ovf  = ovf_reg;

endmodule
`default_nettype wire

/* sv/vertex_transform_perspective_divide.sv */
// Vertex transform by a 4x4 matrix with perspective divide, top level.
//
// Usage: a point (pos_x, pos_y, pos_z), signed fixed point with FRAC_BITS
// fraction bits, moves on the in_valid/in_ready channel; the projected
// point, w and the w_zero/overflow flags leave on out_valid/out_ready.
// One result per input transfer, in order.
// Matrix lives in eight 64-bit APB registers at byte address 8*i; write
// them only while the pipeline is empty.
// Depth: 38 register stages (4 stages for multiply and accumulate,
// 34 for the divider: prep, one stage per quotient bit, saturation).
// Throughput: one vertex per cycle while no result waits stalled;
// three pipelined restoring dividers, one per coordinate, set the depth.
// Reset clears all valid bits and loads the identity matrix.
// When the receiver stalls with a result waiting, the whole pipeline
// holds; in_ready drops until the result is taken. Nothing is dropped.
`default_nettype none
module vertex_transform_perspective_divide #(
    parameter int FRAC_BITS = vtpd_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [vtpd_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [vtpd_pkg::REG_W-1:0]    pwdata,
    output logic      [vtpd_pkg::REG_W-1:0]    prdata,
    output logic                               pready,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [vtpd_pkg::DATA_W-1:0] pos_x,
    input  wire logic signed [vtpd_pkg::DATA_W-1:0] pos_y,
    input  wire logic signed [vtpd_pkg::DATA_W-1:0] pos_z,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [vtpd_pkg::DATA_W-1:0] proj_x,
    output logic signed [vtpd_pkg::DATA_W-1:0] proj_y,
    output logic signed [vtpd_pkg::DATA_W-1:0] proj_z,
    output logic signed [vtpd_pkg::DATA_W-1:0] homog_w,
    output logic                               w_zero,
    output logic                               overflow
);
    import vtpd_pkg::*;

    localparam int ACC_W  = 66 - FRAC_BITS;
    localparam int PROD_W = 2 * DATA_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int WIDE_W = SUM_W + 1;
    localparam int NSTG   = 4 + DIV_LAT;

    logic [REG_W-1:0] mat_reg [NUM_REGS];
    logic [NSTG-1:0]  v_reg;
    logic [NSTG-1:0]  v_next;
    logic             advance;

    logic signed [DATA_W-1:0] pt_reg   [3];
    logic signed [PROD_W-1:0] prod_reg [4][3];
    logic signed [SUM_W-1:0]  sum_reg  [4];
    logic signed [ACC_W-1:0]  acc_reg  [4];
    logic signed [DATA_W-1:0] ent      [4][4];
    logic signed [WIDE_W-1:0] wide     [4];

    side_t side_next;
    side_t side_reg [DIV_LAT];

    logic [DATA_W-1:0] quot [3];
    logic              qovf [3];

    // configuration port
    assign pready = 1'b1;
    assign prdata = mat_reg[paddr[ADDR_W-1:3]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                mat_reg[i] <= REG_RESET[i];
            end
        end
        else if (psel && penable && pwrite && pready)
        begin
            mat_reg[paddr[ADDR_W-1:3]] <= pwdata;
        end
    end

    // matrix entries
    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                ent[r][c] = (c % 2 == 1) ? mat_reg[r*2 + c/2][REG_W-1:DATA_W]
                                         : mat_reg[r*2 + c/2][DATA_W-1:0];
            end
        end
    end

    // pipeline control
    assign advance   = !v_reg[NSTG-1] || out_ready;
    assign in_ready  = advance;
    assign out_valid = v_reg[NSTG-1];
    assign v_next    = {v_reg[NSTG-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (advance)
        begin
            v_reg <= v_next;
        end
    end

    // translation add after floor of the product sum
    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            wide[c] = WIDE_W'(sum_reg[c] >>> FRAC_BITS) + WIDE_W'(ent[3][c]);
        end
    end

    // stage 1: point, stage 2: products, stage 3: sums, stage 4: acc
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pt_reg[0] <= pos_x;
            pt_reg[1] <= pos_y;
            pt_reg[2] <= pos_z;
            for (int c = 0; c < 4; c++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    prod_reg[c][k] <= PROD_W'(pt_reg[k]) * PROD_W'(ent[k][c]);
                end
                sum_reg[c] <= SUM_W'(prod_reg[c][0]) + SUM_W'(prod_reg[c][1])
                            + SUM_W'(prod_reg[c][2]);
                acc_reg[c] <= wide[c][ACC_W-1:0];
            end
        end
    end

    // w flags, delayed alongside the dividers
    always_comb
    begin
        side_next.wz   = acc_reg[3] == '0;
        side_next.wovf = 1'b0;
        side_next.wsat = acc_reg[3][DATA_W-1:0];
        if (acc_reg[3] > ACC_W'($signed(SAT_POS)))
        begin
            side_next.wsat = SAT_POS;
            side_next.wovf = 1'b1;
        end
        else if (acc_reg[3] < ACC_W'($signed(SAT_NEG)))
        begin
            side_next.wsat = SAT_NEG;
            side_next.wovf = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            side_reg[0] <= side_next;
            for (int i = 1; i < DIV_LAT; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // one divider per coordinate
    for (genvar c = 0; c < 3; c++)
    begin : g_div
        vtpd_divider #(
            .FRAC_BITS (FRAC_BITS),
            .ACC_W     (ACC_W)
        ) u_div (
            .clk  (clk),
            .en   (advance),
            .num  (acc_reg[c]),
            .den  (acc_reg[3]),
            .quot (quot[c]),
            .ovf  (qovf[c])
        );
    end

    // output select
    always_comb
    begin
        w_zero   = side_reg[DIV_LAT-1].wz;
        proj_x   = w_zero ? '0 : quot[0];
        proj_y   = w_zero ? '0 : quot[1];
        proj_z   = w_zero ? '0 : quot[2];
        homog_w  = w_zero ? '0 : side_reg[DIV_LAT-1].wsat;
        overflow = !w_zero && (side_reg[DIV_LAT-1].wovf || qovf[0] || qovf[1] || qovf[2]);
    end

    // checks
    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(v_reg))
        else $error("pipeline valids moved during stall");

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> v_reg[0])
        else $error("accepted vertex not in first stage");

    a_wzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && w_zero) |-> (proj_x == 0 && proj_y == 0 && proj_z == 0 && !overflow))
        else $error("zero w result not cleared");

endmodule
`default_nettype wire

/* tb/sv/tb_top.sv */
// Testbench for the vertex transform block: directed table, random phases, scoreboard.
`timescale 1ns / 100ps
module tb_top;
    import vtpd_pkg::*;

    localparam int FRAC       = FRAC_BITS_DEF;
    localparam int DRAIN_WAIT = 45;
    localparam int CYCLE_MAX  = 600000;

    typedef enum int { MAT_IDENT, MAT_ZERO, MAT_TINY_W, MAT_NEG_W } mat_sel_e;

    typedef struct {
        logic signed [DATA_W-1:0] px;
        logic signed [DATA_W-1:0] py;
        logic signed [DATA_W-1:0] pz;
        logic signed [DATA_W-1:0] hw;
        logic                     wz;
        logic                     ovf;
    } vert_t;

    typedef struct {
        mat_sel_e                 msel;
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] z;
        bit                       typed;
        vert_t                    res;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [REG_W-1:0]  pwdata = '0;
    logic [REG_W-1:0]  prdata;
    logic              pready;
    logic in_valid = 1'b0, in_ready;
    logic signed [DATA_W-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
    logic out_valid, out_ready = 1'b0;
    logic signed [DATA_W-1:0] proj_x, proj_y, proj_z, homog_w;
    logic w_zero, overflow;

    logic [REG_W-1:0] matrix [NUM_REGS];
    vert_t            pending_verts [$];
    dir_row_t         dir_rows [$];
    int  errors = 0;
    int  cycles = 0;
    int  n_sent = 0, n_recv = 0, n_wz = 0, n_ovf = 0;
    bit  quiet = 1'b0;
    bit  hold_req = 1'b0;
    bit  typed_next = 1'b0;
    vert_t typed_res;

    vertex_transform_perspective_divide DUT (.*);

    // clock
    initial
    begin
        forever #1 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_MAX)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_top: errors");
            $finish;
        end
    end

    // signed matrix entry at row r, column c
    function automatic logic signed [127:0] mat_entry(int r, int c);
        logic [REG_W-1:0] reg_val;
        reg_val = matrix[r*2 + c/2];
        return (c % 2) ? $signed(reg_val[63:32]) : $signed(reg_val[31:0]);
    endfunction

    function automatic logic signed [DATA_W-1:0] clamp32(logic signed [127:0] v,
                                                         inout logic ovf);
        if (v > 128'sh7FFF_FFFF)
        begin
            ovf = 1'b1;
            return SAT_POS;
        end
        if (v < -128'sh8000_0000)
        begin
            ovf = 1'b1;
            return SAT_NEG;
        end
        return v[DATA_W-1:0];
    endfunction

    // transform a point and divide by w
    function automatic vert_t project_point(logic signed [DATA_W-1:0] x,
                                            logic signed [DATA_W-1:0] y,
                                            logic signed [DATA_W-1:0] z);
        logic signed [127:0] acc [4];
        logic signed [127:0] xs, ys, zs, sum, quo;
        logic                ovf;
        vert_t               v;
        xs = x;
        ys = y;
        zs = z;
        ovf = 1'b0;
        for (int c = 0; c < 4; c++)
        begin
            sum = xs * mat_entry(0, c) + ys * mat_entry(1, c) + zs * mat_entry(2, c);
            acc[c] = (sum >>> FRAC) + mat_entry(3, c);
        end
        if (acc[3] == 0)
        begin
            v = '{px: '0, py: '0, pz: '0, hw: '0, wz: 1'b1, ovf: 1'b0};
            return v;
        end
        quo = (acc[0] <<< FRAC) / acc[3];
        v.px = clamp32(quo, ovf);
        quo = (acc[1] <<< FRAC) / acc[3];
        v.py = clamp32(quo, ovf);
        quo = (acc[2] <<< FRAC) / acc[3];
        v.pz = clamp32(quo, ovf);
        v.hw = clamp32(acc[3], ovf);
        v.wz = 1'b0;
        v.ovf = ovf;
        return v;
    endfunction

    task automatic report(string what, longint exp_v, longint got_v);
        $display("mismatch %s: expected %h got %h (result %0d)", what, exp_v, got_v, n_recv);
        errors++;
    endtask

    // APB register write: setup then access cycle, bus left selected
    task automatic write_reg(int idx, logic [REG_W-1:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(8 * idx);
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        matrix[idx] = val;
    endtask

    // back-to-back writes, then release the bus
    task automatic load_matrix(logic [REG_W-1:0] m [NUM_REGS]);
        for (int i = 0; i < NUM_REGS; i++)
            write_reg(i, m[i]);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // wait for all results, then for the pipeline to empty
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_verts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // offer one point and hold it until the transfer
    task automatic send_point(logic signed [DATA_W-1:0] x, logic signed [DATA_W-1:0] y,
                              logic signed [DATA_W-1:0] z);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid <= 1'b1;
        pos_x <= x;
        pos_y <= y;
        pos_z <= z;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
        pending_verts.push_back(typed_next ? typed_res : project_point(x, y, z));
        n_sent++;
    endtask

    // result checker and receiver stall pattern
    initial
    begin
        int hold;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                vert_t e;
                n_recv++;
                if (pending_verts.size() == 0)
                begin
                    $display("unexpected result %0d", n_recv);
                    errors++;
                end
                else
                begin
                    e = pending_verts.pop_front();
                    if (proj_x !== e.px) report("proj_x", e.px, proj_x);
                    if (proj_y !== e.py) report("proj_y", e.py, proj_y);
                    if (proj_z !== e.pz) report("proj_z", e.pz, proj_z);
                    if (homog_w !== e.hw) report("homog_w", e.hw, homog_w);
                    if (w_zero !== e.wz) report("w_zero", e.wz, w_zero);
                    if (overflow !== e.ovf) report("overflow", e.ovf, overflow);
                    n_wz += e.wz;
                    n_ovf += e.ovf;
                end
            end
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold = 300;
            end
            if (hold > 0)
            begin
                hold--;
                out_ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                hold = $urandom_range(1, 13) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // random coordinate: mostly moderate, sometimes any 32-bit value or an extreme
    function automatic logic signed [DATA_W-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? SAT_POS : SAT_NEG;
            default: return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
        endcase
    endfunction

    function automatic logic [31:0] rand_entry(int kind);
        case (kind)
            0: return $urandom;
            1: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
            default: return $urandom_range(0, 1) ? SAT_POS : SAT_NEG;
        endcase
    endfunction

    task automatic set_named_matrix(mat_sel_e sel);
        logic [REG_W-1:0] m [NUM_REGS];
        m = REG_RESET;
        case (sel)
            MAT_ZERO:   m = '{default: '0};
            MAT_TINY_W: m[7] = {32'd1, 32'd0};
            MAT_NEG_W:  m[7] = {32'hFFFF_0000, 32'd0};
            default: ;
        endcase
        load_matrix(m);
    endtask

    task automatic add_row(mat_sel_e s, int x, int y, int z, bit t, vert_t r);
        dir_row_t row;
        row = '{msel: s, x: x, y: y, z: z, typed: t, res: r};
        dir_rows.push_back(row);
    endtask

    initial
    begin
        logic [REG_W-1:0] m [NUM_REGS];
        mat_sel_e cur;
        vert_t none, zw;
        int kind;
        none = '{default: '0};
        zw = '{px: '0, py: '0, pz: '0, hw: '0, wz: 1'b1, ovf: 1'b0};
        matrix = REG_RESET;

        // identity passes the point through with w = 1.0
        add_row(MAT_IDENT, 0, 0, 0, 1, '{0, 0, 0, 32'h10000, 0, 0});
        add_row(MAT_IDENT, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1,
                '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h10000, 0, 0});
        add_row(MAT_IDENT, 32'h80000000, 32'h80000000, 32'h80000000, 1,
                '{32'h80000000, 32'h80000000, 32'h80000000, 32'h10000, 0, 0});
        add_row(MAT_IDENT, 1, -1, 32'h10000, 1, '{1, -1, 32'h10000, 32'h10000, 0, 0});
        add_row(MAT_IDENT, 32'h7FFFFFFF, 32'h80000000, 32'h5555AAAA, 1,
                '{32'h7FFFFFFF, 32'h80000000, 32'h5555AAAA, 32'h10000, 0, 0});
        add_row(MAT_IDENT, 32'h12345678, 32'hDEADBEEF, 32'hAAAA5555, 0, none);
        // zero matrix: w is zero for every point
        add_row(MAT_ZERO, 0, 0, 0, 1, zw);
        add_row(MAT_ZERO, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 1, zw);
        add_row(MAT_ZERO, 32'h00010000, 32'hFFFF0000, 32'h0, 1, zw);
        // w of one raw unit: large coordinates saturate, zero stays zero
        add_row(MAT_TINY_W, 0, 0, 0, 0, none);
        add_row(MAT_TINY_W, 32'h00010000, 32'hFFFF0000, 1, 0, none);
        add_row(MAT_TINY_W, 32'h7FFFFFFF, 32'h80000000, 32'h0, 0, none);
        // w = -1.0: sign flips, most negative input saturates
        add_row(MAT_NEG_W, 32'h00010000, 32'hFFFF0000, 32'h7FFFFFFF, 0, none);
        add_row(MAT_NEG_W, 32'h80000000, 0, 32'h00000001, 0, none);
        add_row(MAT_IDENT, 32'h00008000, 32'hFFFF8000, 32'h00000003, 0, none);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        cur = MAT_IDENT;
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].msel != cur)
            begin
                drain();
                cur = dir_rows[i].msel;
                set_named_matrix(cur);
            end
            typed_next = dir_rows[i].typed;
            typed_res = dir_rows[i].res;
            send_point(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z);
        end
        typed_next = 1'b0;

        // random phases, each with its own matrix
        for (int ph = 0; ph < 14; ph++)
        begin
            drain();
            kind = (ph == 3) ? 2 : (ph % 3);
            for (int i = 0; i < NUM_REGS; i++)
                m[i] = {rand_entry(kind), rand_entry(kind)};
            // perspective-like matrix: w from z plus an offset
            if (kind == 1 && ph % 2 == 0)
            begin
                m[1] = {32'd0, rand_entry(1)};
                m[3] = {32'd0, rand_entry(1)};
                m[5] = {32'h10000, rand_entry(1)};
                m[7] = {$urandom_range(0, 1) ? 32'h0 : 32'h10000, rand_entry(1)};
            end
            if (ph == 13)
                m = '{default: '1};
            load_matrix(m);
            quiet = (ph >= 12);
            if (ph == 5)
                hold_req = 1'b1;
            for (int k = 0; k < 100; k++)
                send_point(rand_coord(), rand_coord(), rand_coord());
        end
        drain();

        $display("covered %0d points under %0d matrix settings, incl. zero w and saturation",
                 n_sent, 18);
        $display("results %0d, zero-w %0d, saturated %0d", n_recv, n_wz, n_ovf);
        if (errors == 0 && pending_verts.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end
endmodule
